FILE: design/lcpm_pkg.sv
// Shared constants, codes and types for the current loop PWM mapper.
package lcpm_pkg;

  localparam int FLOW_BITS      = 32;
  localparam int COMPARE_BITS   = 13;
  localparam int TIMEOUT_BITS   = 16;
  localparam int CENTI_BITS     = 11;
  localparam int MUL_BITS       = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [CENTI_BITS-1:0]   CENTI_MIN     = CENTI_BITS'(400);
  localparam logic [CENTI_BITS-1:0]   CENTI_MAX     = CENTI_BITS'(2000);
  localparam logic [MUL_BITS-1:0]     CENTI_SPAN    = MUL_BITS'(1600);
  localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = TIMEOUT_BITS'(10000);

  localparam logic [1:0] OP_FLOW      = 2'd0;
  localparam logic [1:0] OP_CAL_WRITE = 2'd1;
  localparam logic [1:0] OP_CAL_EXIT  = 2'd2;
  localparam logic [1:0] OP_TICK      = 2'd3;

  localparam logic [CFG_INDEX_BITS-1:0] REG_CMP_4MA   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CMP_20MA  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FLOW_4MA  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FLOW_20MA = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TIMEOUT   = 3'd4;

  typedef struct packed {
    logic                 start;
    logic [FLOW_BITS-1:0] n;
    logic [FLOW_BITS-1:0] d;
    logic [MUL_BITS-1:0]  m;
  } lcpm_div_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [MUL_BITS-1:0] q;
    logic                rem_nz;
  } lcpm_div_rsp_t;

endpackage

FILE: design/lcpm_if.sv
// Handshake channel interfaces for items, results and configuration writes.
interface lcpm_item_if ();
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           opcode;
  logic signed [lcpm_pkg::FLOW_BITS-1:0] flow_rate;
  logic [lcpm_pkg::COMPARE_BITS-1:0]    cal_compare;
  modport source (output valid, opcode, flow_rate, cal_compare, input ready);
  modport sink (input valid, opcode, flow_rate, cal_compare, output ready);
endinterface

interface lcpm_result_if ();
  logic                              valid;
  logic                              ready;
  logic [lcpm_pkg::COMPARE_BITS-1:0] compare_value;
  logic                              compare_written;
  logic [lcpm_pkg::CENTI_BITS-1:0]   centi_milliamp;
  logic                              calibrating;
  modport source (output valid, compare_value, compare_written, centi_milliamp,
                  calibrating, input ready);
  modport sink (input valid, compare_value, compare_written, centi_milliamp,
                calibrating, output ready);
endinterface

interface lcpm_cfg_if ();
  logic                                valid;
  logic                                ready;
  logic [lcpm_pkg::CFG_INDEX_BITS-1:0] index;
  logic [lcpm_pkg::CFG_DATA_BITS-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: design/loop_current_pwm_mapper.sv
// Tick, write and exit items go straight to finish, which loads the result once the
// output is free. A flow sample passes the difference, magnitude and zone states, then,
// unless clamped, a divider pass for display current and, when not calibrating, one
// for the compare value. One item at a time: a new transfer can follow in the cycle
// after the result loads. Synchronous reset clears calibration state, the driven compare
// value and the registers to their power-up values (timeout 10000 ms, all else 0).
module loop_current_pwm_mapper (
  input  logic           clk,
  input  logic           rst,
  lcpm_item_if.sink      item,
  lcpm_result_if.source  result,
  lcpm_cfg_if.sink       cfg
);

  localparam int FB = lcpm_pkg::FLOW_BITS;
  localparam int CB = lcpm_pkg::COMPARE_BITS;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_DIFF      = 3'd1;
  localparam logic [2:0] S_MAG       = 3'd2;
  localparam logic [2:0] S_ZONE      = 3'd3;
  localparam logic [2:0] S_DIV_CENTI = 3'd4;
  localparam logic [2:0] S_DIV_CMP   = 3'd5;
  localparam logic [2:0] S_FINISH    = 3'd6;

  // Configuration registers
  logic [CB-1:0]                         compare_at_4ma;
  logic [CB-1:0]                         compare_at_20ma;
  logic [FB-1:0]                         flow_at_4ma;
  logic [FB-1:0]                         flow_at_20ma;
  logic [lcpm_pkg::TIMEOUT_BITS-1:0]     timeout_limit;

  // Block state
  logic                                  cal_active;
  logic [lcpm_pkg::TIMEOUT_BITS-1:0]     cal_elapsed_ms;
  logic [CB-1:0]                         drive_compare;

  logic [2:0]                            state;
  logic [1:0]                            op;
  logic [FB-1:0]                         flow;
  logic [CB-1:0]                         cal_cmp;
  logic signed [FB:0]                    num;
  logic signed [FB:0]                    den;
  logic [FB-1:0]                         nm;
  logic [FB-1:0]                         dm;
  logic                                  ns;
  logic                                  ds;
  logic                                  den_zero;
  logic [lcpm_pkg::CENTI_BITS-1:0]       centi;
  logic [CB-1:0]                         cmp_new;

  logic                                  res_valid;
  logic [CB-1:0]                         res_compare;
  logic                                  res_written;
  logic [lcpm_pkg::CENTI_BITS-1:0]       res_centi;
  logic                                  res_cal;

  lcpm_pkg::lcpm_div_req_t               div_req;
  lcpm_pkg::lcpm_div_rsp_t               div_rsp;

  logic                                  zone_low;
  logic                                  zone_high;
  logic                                  ascending;
  logic [CB-1:0]                         span;
  logic                                  out_free;

  logic                                  cal_active_next;
  logic [lcpm_pkg::TIMEOUT_BITS-1:0]     cal_elapsed_next;
  logic [CB-1:0]                         drive_next;
  logic                                  written_next;
  logic [lcpm_pkg::CENTI_BITS-1:0]       centi_next;
  logic [lcpm_pkg::TIMEOUT_BITS-1:0]     elapsed_inc;

  assign cfg.ready  = 1'b1;
  assign item.ready = (state == S_IDLE);
  assign out_free   = !res_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      compare_at_4ma  <= '0;
      compare_at_20ma <= '0;
      flow_at_4ma     <= '0;
      flow_at_20ma    <= '0;
      timeout_limit   <= lcpm_pkg::TIMEOUT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        lcpm_pkg::REG_CMP_4MA:   compare_at_4ma  <= cfg.data[CB-1:0];
        lcpm_pkg::REG_CMP_20MA:  compare_at_20ma <= cfg.data[CB-1:0];
        lcpm_pkg::REG_FLOW_4MA:  flow_at_4ma     <= cfg.data[FB-1:0];
        lcpm_pkg::REG_FLOW_20MA: flow_at_20ma    <= cfg.data[FB-1:0];
        lcpm_pkg::REG_TIMEOUT:   timeout_limit   <= cfg.data[lcpm_pkg::TIMEOUT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // A ratio at or below zero, including a zero-width range, clamps to the 4 mA end.
  assign zone_low  = den_zero || (nm == '0) || (ns != ds);
  assign zone_high = (nm >= dm);
  assign ascending = (compare_at_20ma >= compare_at_4ma);
  assign span      = ascending ? (compare_at_20ma - compare_at_4ma)
                               : (compare_at_4ma - compare_at_20ma);

  always_comb begin
    div_req.n     = nm;
    div_req.d     = dm;
    div_req.m     = (state == S_ZONE) ? lcpm_pkg::CENTI_SPAN : lcpm_pkg::MUL_BITS'(span);
    div_req.start = ((state == S_ZONE) && !zone_low && !zone_high) ||
                    ((state == S_DIV_CENTI) && div_rsp.done && !cal_active);
  end

  lcpm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    cal_active_next  = cal_active;
    cal_elapsed_next = cal_elapsed_ms;
    drive_next       = drive_compare;
    written_next     = 1'b0;
    centi_next       = '0;
    elapsed_inc      = (cal_elapsed_ms == '1) ? cal_elapsed_ms : cal_elapsed_ms + 1'b1;
    unique case (op)
      lcpm_pkg::OP_FLOW: begin
        centi_next = centi;
        if (!cal_active) begin
          drive_next   = cmp_new;
          written_next = 1'b1;
        end
      end
      lcpm_pkg::OP_CAL_WRITE: begin
        cal_active_next  = 1'b1;
        cal_elapsed_next = '0;
        drive_next       = cal_cmp;
        written_next     = 1'b1;
      end
      lcpm_pkg::OP_CAL_EXIT: begin
        cal_active_next  = 1'b0;
        cal_elapsed_next = '0;
      end
      lcpm_pkg::OP_TICK: begin
        if (cal_active) begin
          if (elapsed_inc >= timeout_limit) begin
            cal_active_next  = 1'b0;
            cal_elapsed_next = '0;
          end else begin
            cal_elapsed_next = elapsed_inc;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      op             <= lcpm_pkg::OP_FLOW;
      cal_active     <= 1'b0;
      cal_elapsed_ms <= '0;
      drive_compare  <= '0;
      res_valid      <= 1'b0;
    end else begin
      // The finish state loads the next result itself once the output is free.
      if (res_valid && result.ready && (state != S_FINISH)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item.valid) begin
            op      <= item.opcode;
            flow    <= item.flow_rate;
            cal_cmp <= item.cal_compare;
            state   <= (item.opcode == lcpm_pkg::OP_FLOW) ? S_DIFF : S_FINISH;
          end
        end
        S_DIFF: begin
          num   <= $signed({flow[FB-1], flow}) - $signed({flow_at_4ma[FB-1], flow_at_4ma});
          den   <= $signed({flow_at_20ma[FB-1], flow_at_20ma})
                   - $signed({flow_at_4ma[FB-1], flow_at_4ma});
          state <= S_MAG;
        end
        S_MAG: begin
          ns       <= num[FB];
          ds       <= den[FB];
          nm       <= num[FB] ? FB'(-num) : num[FB-1:0];
          dm       <= den[FB] ? FB'(-den) : den[FB-1:0];
          den_zero <= (den == '0);
          state    <= S_ZONE;
        end
        S_ZONE: begin
          if (zone_low) begin
            centi   <= lcpm_pkg::CENTI_MIN;
            cmp_new <= compare_at_4ma;
            state   <= S_FINISH;
          end else if (zone_high) begin
            centi   <= lcpm_pkg::CENTI_MAX;
            cmp_new <= compare_at_20ma;
            state   <= S_FINISH;
          end else begin
            state <= S_DIV_CENTI;
          end
        end
        S_DIV_CENTI: begin
          if (div_rsp.done) begin
            centi <= lcpm_pkg::CENTI_MIN + lcpm_pkg::CENTI_BITS'(div_rsp.q);
            state <= cal_active ? S_FINISH : S_DIV_CMP;
          end
        end
        S_DIV_CMP: begin
          // A falling range rounds the step up so that the compare value still floors.
          if (div_rsp.done) begin
            if (ascending) begin
              cmp_new <= compare_at_4ma + CB'(div_rsp.q);
            end else begin
              cmp_new <= compare_at_4ma - (CB'(div_rsp.q) + CB'(div_rsp.rem_nz));
            end
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            cal_active     <= cal_active_next;
            cal_elapsed_ms <= cal_elapsed_next;
            drive_compare  <= drive_next;
            res_valid      <= 1'b1;
            res_compare    <= drive_next;
            res_written    <= written_next;
            res_centi      <= centi_next;
            res_cal        <= cal_active_next;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign result.valid           = res_valid;
  assign result.compare_value   = res_compare;
  assign result.compare_written = res_written;
  assign result.centi_milliamp  = res_centi;
  assign result.calibrating     = res_cal;

`ifndef SYNTHESIS
  a_idle_counter_clear: assert property (@(posedge clk) disable iff (rst)
    !cal_active |-> (cal_elapsed_ms == '0))
    else $error("calibration counter nonzero outside calibration");

  a_div_idle_on_accept: assert property (@(posedge clk) disable iff (rst)
    item.ready |-> !div_rsp.busy)
    else $error("divider busy while a new item can be taken");

  a_centi_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.centi_milliamp == '0) ||
                     ((result.centi_milliamp >= lcpm_pkg::CENTI_MIN) &&
                      (result.centi_milliamp <= lcpm_pkg::CENTI_MAX)))
    else $error("display current out of range");

  a_flow_written: assert property (@(posedge clk) disable iff (rst)
    (result.valid && (result.centi_milliamp != '0)) |->
      (result.compare_written == !result.calibrating))
    else $error("flow sample write flag does not follow calibration mode");
`endif

endmodule

FILE: design/lcpm_div.sv
// Shared shift-and-subtract unit computing floor(n * m / d) for n < d, one half bit per cycle.
module lcpm_div (
  input  logic                    clk,
  input  logic                    rst,
  input  lcpm_pkg::lcpm_div_req_t req,
  output lcpm_pkg::lcpm_div_rsp_t rsp
);

  localparam int RB = lcpm_pkg::FLOW_BITS + 1;
  localparam int CB = $clog2(lcpm_pkg::MUL_BITS);

  logic                              busy;
  logic                              phase;
  logic                              done;
  logic [CB-1:0]                     cnt;
  logic [lcpm_pkg::MUL_BITS-1:0]     q;
  logic [RB-1:0]                     r;
  logic [lcpm_pkg::FLOW_BITS-1:0]    n;
  logic [lcpm_pkg::FLOW_BITS-1:0]    d;
  logic [lcpm_pkg::MUL_BITS-1:0]     m;

  logic [RB-1:0]                     operand;
  logic                              ge;
  logic [RB-1:0]                     r_next;
  logic [lcpm_pkg::MUL_BITS-1:0]     q_next;

  // Phase 0 doubles the remainder, phase 1 adds n when the current bit of m is set.
  // Each phase then takes d off once if the remainder reached it.
  always_comb begin
    if (phase) begin
      operand = r + {1'b0, (m[cnt] ? n : '0)};
    end else begin
      operand = {r[RB-2:0], 1'b0};
    end
    ge = (operand >= {1'b0, d});
    r_next = ge ? (operand - {1'b0, d}) : operand;
    if (phase) begin
      q_next = q + lcpm_pkg::MUL_BITS'(ge);
    end else begin
      q_next = {q[lcpm_pkg::MUL_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        phase <= 1'b0;
        cnt   <= CB'(lcpm_pkg::MUL_BITS - 1);
        r     <= '0;
        q     <= '0;
        n     <= req.n;
        d     <= req.d;
        m     <= req.m;
      end else if (busy) begin
        r     <= r_next;
        q     <= q_next;
        phase <= ~phase;
        if (phase) begin
          if (cnt == '0) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
      end
    end
  end

  assign rsp.busy   = busy;
  assign rsp.done   = done;
  assign rsp.q      = q;
  assign rsp.rem_nz = (r != '0);

endmodule
